>>> hw/rtl/swm_pkg.sv
// ============================================================================
// swm_pkg - shared types and constants for the star wildcard name matcher
// Holds the wildcard code, stream codes and the cell control and status types.
// ============================================================================
`default_nettype none

package swm_pkg;

    localparam int CHAR_W = 8;
    localparam int PATTERN_MAX_DEFAULT = 64;

    localparam logic [CHAR_W-1:0] WILDCARD = 8'h2A;

    // values of the kind bit carried on tuser
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_NAME    = 1'b1;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic              write;
        logic [CHAR_W-1:0] wr_char;
        logic [CHAR_W-1:0] name_char;
        logic              update;
    } cell_ctrl_t;

    // per-cell status handed back to the top level
    typedef struct packed {
        logic star_q;
        logic star_next;
        logic keep;
        logic adv;
    } cell_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/star_wildcard_name_matcher.sv
// ============================================================================
// star_wildcard_name_matcher - glob matcher with '*' as the only wildcard
// Loads a pattern byte by byte, then matches streamed names against it.
// ============================================================================
// Each input item is a pattern byte (tuser 0) or a name byte (tuser 1); tlast
// closes the pattern or the name. A new item is taken every cycle: a row of
// PATTERN_MAX cells, one per pattern position, updates its active bits in
// parallel from its left neighbor, and a wide add applies the wildcard
// closure. The match result of a name is registered into a two-entry output
// queue when its last byte is taken, so input is only held off once two
// results wait. A pattern longer than PATTERN_MAX is cut off and flagged, and
// then no name matches until a new pattern arrives.
`default_nettype none

module star_wildcard_name_matcher #(
    parameter int PATTERN_MAX = swm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] character
    input  wire        s_tuser,   // [0] operation
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] pattern_too_long, [7:2] zero
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic accept;
    logic is_load;
    logic is_name;
    logic name_end;

    logic             restart_reg;
    logic             restart_next;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic [LEN_W-1:0] wr_pos;
    logic             do_write;
    logic             room;

    swm_pkg::cell_ctrl_t ctrl;
    swm_pkg::cell_stat_t stat [PATTERN_MAX];

    logic [PATTERN_MAX:0]   act_q;
    logic [PATTERN_MAX-1:0] keep;
    logic [PATTERN_MAX-1:0] adv;
    logic [PATTERN_MAX-1:0] star_q;
    logic [PATTERN_MAX-1:0] star_n;
    logic [PATTERN_MAX:0]   stepped;
    logic [PATTERN_MAX:0]   step_closed;
    logic [PATTERN_MAX:0]   init_closed;
    logic [PATTERN_MAX:0]   active_d;
    logic                   active_upd;
    logic                   act_end_reg;

    logic       res_matched;
    logic [1:0] res_data;
    logic       push;
    logic       pop;
    logic       out_valid_reg;
    logic [1:0] out_data_reg;
    logic       skid_valid_reg;
    logic [1:0] skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign is_load  = accept && (s_tuser == swm_pkg::OP_PATTERN);
    assign is_name  = accept && (s_tuser == swm_pkg::OP_NAME);
    assign name_end = is_name && s_tlast;

    // pattern length and overflow bookkeeping
    assign room = length_reg < LEN_W'(PATTERN_MAX);

    always_comb
    begin
        restart_next  = restart_reg;
        length_next   = length_reg;
        overflow_next = overflow_reg;
        wr_pos        = restart_reg ? '0 : length_reg;
        do_write      = 1'b0;
        if (is_load)
        begin
            restart_next = s_tlast;
            if (restart_reg)
            begin
                length_next   = LEN_W'(1);
                overflow_next = 1'b0;
                do_write      = 1'b1;
            end
            else if (room)
            begin
                length_next = length_reg + LEN_W'(1);
                do_write    = 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg  <= 1'b1;
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            restart_reg  <= restart_next;
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

    assign ctrl.write     = do_write;
    assign ctrl.wr_char   = s_tdata;
    assign ctrl.name_char = s_tdata;
    assign ctrl.update    = active_upd;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            swm_cell #(
                .LEN_W (LEN_W),
                .INDEX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .wr_pos      (wr_pos),
                .length_next (length_next),
                .act_d       (active_d[gi]),
                .act         (act_q[gi]),
                .stat        (stat[gi])
            );
            assign keep[gi]   = stat[gi].keep;
            assign adv[gi]    = stat[gi].adv;
            assign star_q[gi] = stat[gi].star_q;
            assign star_n[gi] = stat[gi].star_next;
        end
    endgenerate

    // position past the end of the pattern has no byte of its own
    assign act_q[PATTERN_MAX] = act_end_reg;

    assign stepped = {adv, 1'b0} | {1'b0, keep};

    swm_closure #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_step_closure (
        .act_in  (stepped),
        .star    (star_q),
        .act_out (step_closed)
    );

    // fresh name start set, against the pattern as it stands after this item
    swm_closure #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_init_closure (
        .act_in  ((PATTERN_MAX + 1)'(1)),
        .star    (star_n),
        .act_out (init_closed)
    );

    assign active_upd = is_load || is_name;
    assign active_d   = (is_load || name_end) ? init_closed : step_closed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_end_reg <= 1'b0;
        end
        else if (active_upd)
        begin
            act_end_reg <= active_d[PATTERN_MAX];
        end
    end

    assign res_matched = step_closed[length_reg] && !overflow_reg;
    assign res_data    = {overflow_reg, res_matched};

    // two-entry output queue
    assign push = name_end;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg)
        begin
            if (pop && !push)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (!pop && push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= res_data;
            end
            else
            begin
                skid_data_reg <= res_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg};

endmodule

`default_nettype wire

>>> hw/rtl/swm_cell.sv
// ============================================================================
// swm_cell - one pattern position of the matcher chain
// Holds one pattern byte, its wildcard and in-pattern flags and the active bit
// of this position; reports what it keeps and what it hands to its neighbor.
// ============================================================================
`default_nettype none

module swm_cell #(
    parameter int LEN_W = 7,
    parameter int INDEX = 0
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  swm_pkg::cell_ctrl_t     ctrl,
    input  wire  [LEN_W-1:0]        wr_pos,
    input  wire  [LEN_W-1:0]        length_next,
    input  wire                     act_d,
    output logic                    act,
    output swm_pkg::cell_stat_t     stat
);

    logic [swm_pkg::CHAR_W-1:0] char_reg;
    logic [swm_pkg::CHAR_W-1:0] char_next;
    logic                       star_reg;
    logic                       star_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       act_reg;
    logic                       wr_en;

    assign wr_en      = ctrl.write && (wr_pos == LEN_W'(INDEX));
    assign char_next  = wr_en ? ctrl.wr_char : char_reg;
    assign valid_next = LEN_W'(INDEX) < length_next;
    assign star_next  = valid_next && (char_next == swm_pkg::WILDCARD);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_reg <= ctrl.wr_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg  <= 1'b0;
            valid_reg <= 1'b0;
            act_reg   <= (INDEX == 0) ? 1'b1 : 1'b0;
        end
        else
        begin
            star_reg  <= star_next;
            valid_reg <= valid_next;
            if (ctrl.update)
            begin
                act_reg <= act_d;
            end
        end
    end

    assign act            = act_reg;
    assign stat.star_q    = star_reg;
    assign stat.star_next = star_next;
    // a wildcard holds its position, a literal advances on a byte match
    assign stat.keep      = act_reg && star_reg;
    assign stat.adv       = act_reg && valid_reg && !star_reg
                            && (char_reg == ctrl.name_char);

endmodule

`default_nettype wire

>>> hw/rtl/swm_closure.sv
// ============================================================================
// swm_closure - wildcard closure of an active position set
// Every active wildcard also activates the rest of its run of wildcards and
// the position after that run; computed as the carry chain of one wide add.
// ============================================================================
`default_nettype none

module swm_closure #(
    parameter int PATTERN_MAX = 64
) (
    input  wire  [PATTERN_MAX:0]   act_in,
    input  wire  [PATTERN_MAX-1:0] star,
    output logic [PATTERN_MAX:0]   act_out
);

    logic [PATTERN_MAX:0] add_a;
    logic [PATTERN_MAX:0] add_b;
    logic [PATTERN_MAX:0] sum;
    logic [PATTERN_MAX:0] carry;

    // generate = active wildcard, propagate = idle wildcard
    assign add_a   = {1'b0, star};
    assign add_b   = {1'b0, act_in[PATTERN_MAX-1:0] & star};
    assign sum     = add_a + add_b;
    assign carry   = sum ^ add_a ^ add_b;
    assign act_out = act_in | carry;

endmodule

`default_nettype wire
